// ===== rtl/tpnfba_pkg.sv =====
// Shared constants and widths for the two-pool next-fit block allocator.
package tpnfba_pkg;

  localparam int LARGE_BLOCKS_DEF      = 16;
  localparam int SMALL_BLOCKS_DEF      = 64;
  localparam int SMALL_BLOCK_BYTES_DEF = 1024;

  localparam int BYTES_W  = 29;
  localparam int OFFSET_W = 28;
  localparam int LBB_W    = 24;
  localparam int MAP_W    = 6;

  // Shared divider: dividend covers bytes + large_block_bytes - 1.
  localparam int DIV_W  = 30;
  localparam int DIVS_W = 24;

  localparam logic [MAP_W-1:0] CONT_MARK = 6'd63;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic POOL_LARGE = 1'b0;
  localparam logic POOL_SMALL = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FREED     = 2'd1;
  localparam logic [1:0] ST_REFUSED   = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

endpackage

// ===== rtl/tpnfba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpnfba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tpnfba_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tpnfba_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpnfba_pkg::DIV_W-1:0]  dividend,
  input  logic [tpnfba_pkg::DIVS_W-1:0] divisor,
  output logic                          done,
  output logic [tpnfba_pkg::DIV_W-1:0]  quot,
  output logic [tpnfba_pkg::DIVS_W-1:0] rem
);

  localparam int CW = $clog2(tpnfba_pkg::DIV_W + 1);

  logic [tpnfba_pkg::DIVS_W-1:0] dvs;
  logic [tpnfba_pkg::DIVS_W:0]   part;
  logic [tpnfba_pkg::DIVS_W:0]   shifted;
  logic [CW-1:0]                 cnt;
  logic                          busy;

  assign shifted = {part[tpnfba_pkg::DIVS_W-1:0], quot[tpnfba_pkg::DIV_W-1]};
  assign rem     = part[tpnfba_pkg::DIVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        part <= '0;
        quot <= dividend;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          part <= shifted - {1'b0, dvs};
          quot <= {quot[tpnfba_pkg::DIV_W-2:0], 1'b1};
        end else begin
          part <= shifted;
          quot <= {quot[tpnfba_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(tpnfba_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/two_pool_next_fit_block_allocator.sv =====
// Top level of the two-pool next-fit block allocator.
//
// Input channel (in_valid/in_stall): one transaction is an allocate
// (mode 0, request_bytes) or a free (mode 1, free_pool, free_offset).
// Output channel (out_valid/out_stall): one result per accepted item
// not cut off by a config write, in order: status, alloc_pool, alloc_offset.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes large_block_bytes
// and clears both block maps; rovers are kept.
// One item is handled at a time; in_stall is high until the block is idle
// and while a config write is offered.
// Small allocate: reads and checks each probed block from the rover, up to SMALL_BLOCKS.
// Large allocate: a divide, then a read and check per scanned block over up
// to LARGE_BLOCKS + n - 1 blocks, then one map write per block of a run of n.
// Large frees: a divide, a map read, a backward walk over up to LARGE_BLOCKS
// entries and one map write per cleared block; small frees divide, then clear one bit.
// Reset and each config write start a clearing pass over
// max(LARGE_BLOCKS, SMALL_BLOCKS) map addresses; no item is taken meanwhile.
// A stalled result sits in the output register; the next item may be taken
// and worked on, and its result waits until the register frees up.
module two_pool_next_fit_block_allocator #(
  parameter int LARGE_BLOCKS      = tpnfba_pkg::LARGE_BLOCKS_DEF,
  parameter int SMALL_BLOCKS      = tpnfba_pkg::SMALL_BLOCKS_DEF,
  parameter int SMALL_BLOCK_BYTES = tpnfba_pkg::SMALL_BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [tpnfba_pkg::BYTES_W-1:0]  request_bytes,
  input  logic                            free_pool,
  input  logic [tpnfba_pkg::OFFSET_W-1:0] free_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic                            alloc_pool,
  output logic [tpnfba_pkg::OFFSET_W-1:0] alloc_offset,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpnfba_pkg::LBB_W-1:0]    cfg_data
);

  localparam int LAW    = $clog2(LARGE_BLOCKS);
  localparam int SAW    = $clog2(SMALL_BLOCKS);
  localparam int NW     = $clog2(LARGE_BLOCKS + 1);
  localparam int MAXB   = (LARGE_BLOCKS > SMALL_BLOCKS) ? LARGE_BLOCKS : SMALL_BLOCKS;
  localparam int CNTW   = $clog2(2 * MAXB + 1);
  localparam int SLIMIT = SMALL_BLOCKS * SMALL_BLOCK_BYTES;
  localparam int MW     = tpnfba_pkg::MAP_W;

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_DIV   = 15'b000000000000100,
    S_SRD   = 15'b000000000001000,
    S_SCHK  = 15'b000000000010000,
    S_SFREE = 15'b000000000100000,
    S_LRD   = 15'b000000001000000,
    S_LCHK  = 15'b000000010000000,
    S_LWR   = 15'b000000100000000,
    S_FRD   = 15'b000001000000000,
    S_FCHK  = 15'b000010000000000,
    S_BRD   = 15'b000100000000000,
    S_BCHK  = 15'b001000000000000,
    S_FCLR  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state;

  logic [tpnfba_pkg::LBB_W-1:0]    lbb;
  logic [tpnfba_pkg::DIV_W-1:0]    lim;
  logic [LAW-1:0]                  lrover;
  logic [SAW-1:0]                  srover;
  logic [LAW-1:0]                  l_pos;
  logic [SAW-1:0]                  s_pos;
  logic [LAW-1:0]                  start;
  logic [NW-1:0]                   need;
  logic [NW-1:0]                   run;
  logic [CNTW-1:0]                 cnt;
  logic                            req_mode;
  logic                            req_pool;
  logic [1:0]                      res_status;
  logic                            res_pool;
  logic [tpnfba_pkg::OFFSET_W-1:0] res_offset;

  // Map RAM ports.
  logic            lm_we;
  logic [LAW-1:0]  lm_waddr;
  logic [MW-1:0]   lm_wdata;
  logic [MW-1:0]   lm_rdata;
  logic            sm_we;
  logic [SAW-1:0]  sm_waddr;
  logic            sm_wdata;
  logic            sm_rdata;

  // Divider ports.
  logic                          div_go;
  logic                          div_done;
  logic [tpnfba_pkg::DIV_W-1:0]  div_dividend;
  logic [tpnfba_pkg::DIVS_W-1:0] div_divisor;
  logic [tpnfba_pkg::DIV_W-1:0]  div_quot;
  logic [tpnfba_pkg::DIVS_W-1:0] div_rem;

  logic           alloc_req;
  logic           bad_alloc;
  logic           small_req;
  logic           small_oob;
  logic           large_oob;
  logic [LAW-1:0] l_inc;
  logic [LAW-1:0] l_dec;
  logic [SAW-1:0] s_inc;
  logic [NW-1:0]  run_n;
  logic [LAW:0]   start_raw;
  logic [LAW-1:0] start_calc;
  logic           out_free;
  logic           load_out;

  tpnfba_ram #(.WIDTH(MW), .DEPTH(LARGE_BLOCKS)) u_large_map (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .raddr (l_pos),
    .rdata (lm_rdata)
  );

  tpnfba_ram #(.WIDTH(1), .DEPTH(SMALL_BLOCKS)) u_small_map (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .raddr (s_pos),
    .rdata (sm_rdata)
  );

  tpnfba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Hold input while a config write is offered; the write wins the edge.
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == S_DONE) && out_free && !(cfg_valid && cfg_ready);

  assign alloc_req = (mode == tpnfba_pkg::MODE_ALLOC);
  assign bad_alloc = (request_bytes == '0) || (lbb == '0);
  assign small_req = (request_bytes <= tpnfba_pkg::BYTES_W'(SMALL_BLOCK_BYTES));
  assign small_oob = ({4'b0, free_offset} >= 32'(SLIMIT));
  assign large_oob = ({2'b0, free_offset} >= lim);

  assign div_go = !in_stall && in_valid &&
                  (alloc_req ? (!bad_alloc && !small_req)
                             : ((lbb != '0) &&
                                ((free_pool == tpnfba_pkg::POOL_SMALL) ? !small_oob
                                                                       : !large_oob)));
  assign div_dividend = alloc_req
      ? ({1'b0, request_bytes} + {6'b0, lbb} - tpnfba_pkg::DIV_W'(1))
      : {2'b0, free_offset};
  assign div_divisor = (alloc_req || (free_pool == tpnfba_pkg::POOL_LARGE))
      ? lbb : tpnfba_pkg::DIVS_W'(SMALL_BLOCK_BYTES);

  assign l_inc = (l_pos == LAW'(LARGE_BLOCKS - 1)) ? '0 : l_pos + 1'b1;
  assign l_dec = (l_pos == '0) ? LAW'(LARGE_BLOCKS - 1) : l_pos - 1'b1;
  assign s_inc = (s_pos == SAW'(SMALL_BLOCKS - 1)) ? '0 : s_pos + 1'b1;

  assign run_n     = (lm_rdata == '0) ? run + 1'b1 : '0;
  // Start of the run that ends at l_pos, with wrap.
  assign start_raw = {1'b0, l_pos} + (LAW+1)'(1) + (LAW+1)'(LARGE_BLOCKS)
                     - (LAW+1)'(need);
  assign start_calc = (start_raw >= (LAW+1)'(LARGE_BLOCKS))
      ? LAW'(start_raw - (LAW+1)'(LARGE_BLOCKS)) : start_raw[LAW-1:0];

  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = l_pos;
    lm_wdata = '0;
    sm_we    = 1'b0;
    sm_waddr = s_pos;
    sm_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        lm_we    = (cnt < CNTW'(LARGE_BLOCKS));
        lm_waddr = cnt[LAW-1:0];
        sm_we    = (cnt < CNTW'(SMALL_BLOCKS));
        sm_waddr = cnt[SAW-1:0];
      end
      S_SCHK: begin
        sm_we    = (sm_rdata == 1'b0);
        sm_wdata = 1'b1;
      end
      S_SFREE: begin
        sm_we = 1'b1;
      end
      S_LWR: begin
        lm_we    = 1'b1;
        lm_wdata = (cnt == '0) ? MW'(need) : tpnfba_pkg::CONT_MARK;
      end
      S_FCLR: begin
        lm_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      lbb       <= '0;
      lim       <= '0;
      lrover    <= '0;
      srover    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        lbb   <= cfg_data;
        lim   <= tpnfba_pkg::DIV_W'(LARGE_BLOCKS) * {6'b0, cfg_data};
        state <= S_CLEAR;
        cnt   <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            cnt <= cnt + 1'b1;
            if (cnt == CNTW'(MAXB - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              req_mode   <= mode;
              req_pool   <= free_pool;
              res_pool   <= 1'b0;
              res_offset <= '0;
              if (div_go) begin
                state <= S_DIV;
              end else if (alloc_req) begin
                if (bad_alloc) begin
                  res_status <= tpnfba_pkg::ST_REFUSED;
                  state      <= S_DONE;
                end else begin
                  s_pos <= srover;
                  cnt   <= '0;
                  state <= S_SRD;
                end
              end else begin
                res_status <= tpnfba_pkg::ST_IGNORED;
                state      <= S_DONE;
              end
            end
          end
          S_DIV: begin
            if (div_done) begin
              if (req_mode == tpnfba_pkg::MODE_ALLOC) begin
                if (div_quot > tpnfba_pkg::DIV_W'(LARGE_BLOCKS)) begin
                  res_status <= tpnfba_pkg::ST_REFUSED;
                  state      <= S_DONE;
                end else begin
                  need  <= div_quot[NW-1:0];
                  l_pos <= lrover;
                  run   <= '0;
                  cnt   <= '0;
                  state <= S_LRD;
                end
              end else if (req_pool == tpnfba_pkg::POOL_SMALL) begin
                s_pos <= div_quot[SAW-1:0];
                state <= S_SFREE;
              end else if (div_rem != '0) begin
                res_status <= tpnfba_pkg::ST_IGNORED;
                state      <= S_DONE;
              end else begin
                l_pos <= div_quot[LAW-1:0];
                state <= S_FRD;
              end
            end
          end
          S_SRD: begin
            state <= S_SCHK;
          end
          S_SCHK: begin
            if (sm_rdata == 1'b0) begin
              srover     <= s_inc;
              res_status <= tpnfba_pkg::ST_ALLOCATED;
              res_pool   <= tpnfba_pkg::POOL_SMALL;
              res_offset <= tpnfba_pkg::OFFSET_W'(
                  tpnfba_pkg::OFFSET_W'(s_pos) * tpnfba_pkg::OFFSET_W'(SMALL_BLOCK_BYTES));
              state      <= S_DONE;
            end else if (cnt == CNTW'(SMALL_BLOCKS - 1)) begin
              res_status <= tpnfba_pkg::ST_REFUSED;
              state      <= S_DONE;
            end else begin
              cnt   <= cnt + 1'b1;
              s_pos <= s_inc;
              state <= S_SRD;
            end
          end
          S_SFREE: begin
            srover     <= s_pos;
            res_status <= tpnfba_pkg::ST_FREED;
            state      <= S_DONE;
          end
          S_LRD: begin
            state <= S_LCHK;
          end
          S_LCHK: begin
            if (run_n == need) begin
              start <= start_calc;
              l_pos <= start_calc;
              cnt   <= '0;
              state <= S_LWR;
            end else if (cnt == CNTW'(LARGE_BLOCKS) + CNTW'(need) - CNTW'(2)) begin
              res_status <= tpnfba_pkg::ST_REFUSED;
              state      <= S_DONE;
            end else begin
              run   <= run_n;
              cnt   <= cnt + 1'b1;
              l_pos <= l_inc;
              state <= S_LRD;
            end
          end
          S_LWR: begin
            cnt   <= cnt + 1'b1;
            l_pos <= l_inc;
            if (cnt == CNTW'(need) - CNTW'(1)) begin
              lrover     <= l_inc;
              res_status <= tpnfba_pkg::ST_ALLOCATED;
              res_pool   <= tpnfba_pkg::POOL_LARGE;
              res_offset <= tpnfba_pkg::OFFSET_W'(32'(start) * {8'b0, lbb});
              state      <= S_DONE;
            end
          end
          S_FRD: begin
            state <= S_FCHK;
          end
          S_FCHK: begin
            if (lm_rdata == '0) begin
              res_status <= tpnfba_pkg::ST_IGNORED;
              state      <= S_DONE;
            end else if (lm_rdata == tpnfba_pkg::CONT_MARK) begin
              cnt   <= '0;
              l_pos <= l_dec;
              state <= S_BRD;
            end else begin
              need  <= NW'(lm_rdata);
              start <= l_pos;
              cnt   <= '0;
              state <= S_FCLR;
            end
          end
          S_BRD: begin
            state <= S_BCHK;
          end
          S_BCHK: begin
            // Walk back to the head of the run; a free entry ends the walk.
            if (lm_rdata == '0) begin
              res_status <= tpnfba_pkg::ST_IGNORED;
              state      <= S_DONE;
            end else if (lm_rdata != tpnfba_pkg::CONT_MARK) begin
              need  <= NW'(lm_rdata);
              start <= l_pos;
              cnt   <= '0;
              state <= S_FCLR;
            end else if (cnt == CNTW'(LARGE_BLOCKS - 1)) begin
              res_status <= tpnfba_pkg::ST_IGNORED;
              state      <= S_DONE;
            end else begin
              cnt   <= cnt + 1'b1;
              l_pos <= l_dec;
              state <= S_BRD;
            end
          end
          S_FCLR: begin
            cnt   <= cnt + 1'b1;
            l_pos <= l_inc;
            if (cnt == CNTW'(need) - CNTW'(1)) begin
              lrover     <= start;
              res_status <= tpnfba_pkg::ST_FREED;
              state      <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_free) begin
              status       <= res_status;
              alloc_pool   <= res_pool;
              alloc_offset <= res_offset;
              state        <= S_IDLE;
            end
          end
          default: begin
            state <= S_CLEAR;
            cnt   <= '0;
          end
        endcase
      end
    end
  end

  a_no_payload_on_failure: assert property (@(posedge clk) disable iff (rst)
      (out_valid && (status != tpnfba_pkg::ST_ALLOCATED)) |->
      ((alloc_pool == 1'b0) && (alloc_offset == '0)))
    else $error("failed transaction carries a region");

  a_rover_in_range: assert property (@(posedge clk) disable iff (rst)
      (int'(lrover) < LARGE_BLOCKS) && (int'(srover) < SMALL_BLOCKS))
    else $error("rover out of range");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
      (cfg_valid && cfg_ready) |=> (state == S_CLEAR) && (cnt == '0))
    else $error("config write did not start a clearing pass");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
      (state == S_DONE && out_free) |=> (state == S_IDLE) || (state == S_CLEAR))
    else $error("result load did not return to idle");

endmodule

// ===== dv/two_pool_next_fit_block_allocator_checker.sv =====
// Checker for the two-pool allocator: predicts each result and compares the output stream.
`timescale 1ns / 1ps
module two_pool_next_fit_block_allocator_checker
  import tpnfba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                mode,
  input  logic [BYTES_W-1:0]  request_bytes,
  input  logic                free_pool,
  input  logic [OFFSET_W-1:0] free_offset,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          status,
  input  logic                alloc_pool,
  input  logic [OFFSET_W-1:0] alloc_offset,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [LBB_W-1:0]    cfg_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  accepted_count,
  output int                  cfg_count,
  output int                  alloc_ok_count,
  output int                  freed_count
);
  localparam int NL = LARGE_BLOCKS_DEF;
  localparam int NS = SMALL_BLOCKS_DEF;
  localparam longint SBB = SMALL_BLOCK_BYTES_DEF;

  typedef struct packed {
    logic [1:0]          st;
    logic                pool;
    logic [OFFSET_W-1:0] offset;
  } outcome_t;

  outcome_t            expected_outcomes[$];
  logic [MAP_W-1:0]    large_blocks[NL];
  bit                  small_blocks[NS];
  int                  large_next;
  int                  small_next;
  logic [LBB_W-1:0]    block_size;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_maps();
    foreach (large_blocks[i]) large_blocks[i] = '0;
    foreach (small_blocks[i]) small_blocks[i] = 1'b0;
  endfunction

  function automatic logic [1:0] release_large(input longint off);
    longint lbb;
    int idx, n, j;
    lbb = block_size;
    if (off >= NL * lbb || off % lbb != 0) return ST_IGNORED;
    idx = int'(off / lbb);
    n = large_blocks[idx];
    if (n == CONT_MARK) begin
      // walk back to the head of the run
      j = idx;
      n = 0;
      for (int s = 0; s < NL; s++) begin
        j = (j + NL - 1) % NL;
        if (large_blocks[j] == 0) return ST_IGNORED;
        if (large_blocks[j] != CONT_MARK) begin
          idx = j;
          n = large_blocks[j];
          break;
        end
      end
    end
    if (n == 0 || n == CONT_MARK) return ST_IGNORED;
    for (int k = 0; k < n; k++) large_blocks[(idx + k) % NL] = '0;
    large_next = idx;
    return ST_FREED;
  endfunction

  function automatic outcome_t allocate_or_free(input logic m, input logic [BYTES_W-1:0] b,
                                                input logic p, input logic [OFFSET_W-1:0] off);
    outcome_t r;
    longint lbb, need;
    int i, start;
    bit fits;
    r = '0;
    lbb = block_size;
    if (m == MODE_FREE) begin
      if (lbb == 0) r.st = ST_IGNORED;
      else if (p == POOL_LARGE) r.st = release_large(off);
      else if (off >= NS * SBB) r.st = ST_IGNORED;
      else begin
        i = int'(off / SBB);
        small_blocks[i] = 1'b0;
        small_next = i;
        r.st = ST_FREED;
      end
      return r;
    end
    r.st = ST_REFUSED;
    if (b == 0 || lbb == 0) return r;
    if (b <= SBB) begin
      for (int c = 0; c < NS; c++) begin
        i = (small_next + c) % NS;
        if (!small_blocks[i]) begin
          small_blocks[i] = 1'b1;
          small_next = (i + 1) % NS;
          r.st = ST_ALLOCATED;
          r.pool = POOL_SMALL;
          r.offset = OFFSET_W'(i * SBB);
          return r;
        end
      end
      return r;
    end
    need = (longint'(b) + lbb - 1) / lbb;
    if (need > NL) return r;
    for (int c = 0; c < NL; c++) begin
      start = (large_next + c) % NL;
      fits = 1'b1;
      for (int k = 0; k < need; k++)
        if (large_blocks[(start + k) % NL] != 0) fits = 1'b0;
      if (fits) begin
        large_blocks[start] = MAP_W'(need);
        for (int k = 1; k < need; k++) large_blocks[(start + k) % NL] = CONT_MARK;
        large_next = int'((start + need) % NL);
        r.st = ST_ALLOCATED;
        r.pool = POOL_LARGE;
        r.offset = OFFSET_W'(start * lbb);
        return r;
      end
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    accepted_count = 0;
    cfg_count = 0;
    alloc_ok_count = 0;
    freed_count = 0;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      clear_maps();
      large_next = 0;
      small_next = 0;
      block_size = '0;
      expected_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_size = cfg_data;
        clear_maps();
        cfg_count <= cfg_count + 1;
      end
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(allocate_or_free(mode, request_bytes, free_pool,
                                                     free_offset));
        accepted_count <= accepted_count + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with no transaction outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (status != want.st) report("status", status, want.st);
          if (alloc_pool != want.pool) report("alloc_pool", alloc_pool, want.pool);
          if (alloc_offset != want.offset) report("alloc_offset", alloc_offset, want.offset);
          if (want.st == ST_ALLOCATED) alloc_ok_count++;
          if (want.st == ST_FREED) freed_count++;
        end
      end
    end
    pending_count = expected_outcomes.size();
  end

endmodule

// ===== dv/two_pool_next_fit_block_allocator_test.sv =====
// Testbench top: drives allocate and free traffic and configuration, reports the verdict.
`timescale 1ns / 1ps
module two_pool_next_fit_block_allocator_test;
  import tpnfba_pkg::*;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                mode;
  logic [BYTES_W-1:0]  request_bytes;
  logic                free_pool;
  logic [OFFSET_W-1:0] free_offset;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic                alloc_pool;
  logic [OFFSET_W-1:0] alloc_offset;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LBB_W-1:0]    cfg_data;

  int fail_count, pending_count, accepted_count, cfg_count, alloc_ok_count, freed_count;
  int send_idle_pct, recv_idle_pct;
  int unsigned lbb_now;

  two_pool_next_fit_block_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .request_bytes(request_bytes), .free_pool(free_pool),
    .free_offset(free_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .alloc_pool(alloc_pool), .alloc_offset(alloc_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  two_pool_next_fit_block_allocator_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .request_bytes(request_bytes), .free_pool(free_pool),
    .free_offset(free_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .alloc_pool(alloc_pool), .alloc_offset(alloc_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .accepted_count(accepted_count), .cfg_count(cfg_count),
    .alloc_ok_count(alloc_ok_count), .freed_count(freed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < recv_idle_pct);

  // Hold one transaction until the checker sees it accepted.
  task automatic send_item(input logic m, input logic [BYTES_W-1:0] b, input logic p,
                           input logic [OFFSET_W-1:0] off);
    int prev;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode = m;
    request_bytes = b;
    free_pool = p;
    free_offset = off;
    in_valid = 1'b1;
    prev = accepted_count;
    do @(negedge clk); while (accepted_count == prev);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_block_size(input int unsigned v);
    int prev;
    drain();
    cfg_data = LBB_W'(v);
    cfg_valid = 1'b1;
    prev = cfg_count;
    do @(negedge clk); while (cfg_count == prev);
    cfg_valid = 1'b0;
    lbb_now = v;
  endtask

  task automatic alloc(input longint b);
    send_item(MODE_ALLOC, BYTES_W'(b), 1'($urandom_range(0, 1)), OFFSET_W'($urandom));
  endtask

  task automatic release_at(input logic p, input longint off);
    send_item(MODE_FREE, BYTES_W'($urandom_range(0, 268435456)), p, OFFSET_W'(off));
  endtask

  task automatic random_item(input int n);
    int pick;
    longint lbb;
    longint b;
    lbb = (lbb_now == 0) ? 1 : lbb_now;
    pick = $urandom_range(0, 99);
    if (n == 100) drain();
    if (pick < 28) alloc($urandom_range(1, 1024));
    else if (pick < 50) begin
      b = longint'($urandom_range(1, 5)) * lbb - longint'($urandom_range(0, 2));
      alloc((b < 0) ? 0 : b);
    end
    else if (pick < 55) alloc($urandom_range(0, 268435456));
    else if (pick < 57) alloc(0);
    else if (pick < 77) release_at(POOL_LARGE, longint'($urandom_range(0, 16)) * lbb);
    else if (pick < 80) release_at(POOL_LARGE, $urandom_range(0, 32'h0FFF_FFFF));
    else if (pick < 95) release_at(POOL_SMALL, $urandom_range(0, 66000));
    else release_at(POOL_SMALL, $urandom_range(0, 32'h0FFF_FFFF));
  endtask

  initial begin
    int unsigned sizes[5];
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ALLOC;
    request_bytes = '0;
    free_pool = POOL_LARGE;
    free_offset = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    lbb_now = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // unprepared: everything refused or ignored
    alloc(1);
    release_at(POOL_SMALL, 0);
    release_at(POOL_LARGE, 0);
    set_block_size(0);
    alloc(100);

    set_block_size(4096);
    alloc(0);
    alloc(1);
    alloc(1024);
    alloc(1025);
    alloc(4096 * 3);
    alloc(4096 * 16 + 1);
    alloc(268435456);
    release_at(POOL_LARGE, 4096 * 2);      // continuation -> frees whole run
    release_at(POOL_LARGE, 4096 * 2);      // now free: ignored
    release_at(POOL_LARGE, 4097);          // unaligned
    release_at(POOL_LARGE, 4096 * 16);     // past the pool
    alloc(4096 * 14);                      // fits in blocks 1 to 14, no wrap
    release_at(POOL_SMALL, 1500);          // inside a block
    release_at(POOL_SMALL, 5000);          // already free
    release_at(POOL_SMALL, 64 * 1024);     // past the pool
    release_at(POOL_SMALL, 32'h0FFF_FFFF);
    set_block_size(16777215);
    alloc(16777215 * 16);
    release_at(POOL_LARGE, 16777215 * 15);
    alloc(16777215);

    sizes[0] = 1;
    sizes[1] = 1100;
    sizes[2] = 4096;
    sizes[3] = $urandom_range(2, 16777215);
    sizes[4] = 16777215;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 86 : 0;
      recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 9 : 0;
      for (int n = 0; n < 217; n++) begin
        if (n % 72 == 0) set_block_size(sizes[(ph * 3 + n / 72) % 5]);
        random_item(n);
      end
    end
    in_valid = 1'b0;

    drain();
    $display("covered %0d transactions over %0d block sizes: %0d allocated, %0d freed",
             accepted_count, cfg_count, alloc_ok_count, freed_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
